[rtl/core/irt_pkg.sv]
// ----------------------------------------------------------------------------
// irt_pkg: Interval reservation table package
// Sizes, status codes and shared types for the interval reservation table.
// ----------------------------------------------------------------------------
package irt_pkg;

  // Table geometry and time width.
  localparam int TABLE_ENTRIES = 64;
  localparam int TIME_BITS     = 32;

  // Derived widths: slot address, and a count that can hold the full depth.
  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W = 2 * TIME_BITS;

  // Fixed port widths.
  localparam int IN_W     = 32;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_BOOKED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

  // Access request from the controller to the slot memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] wdata;
  } mem_req_t;

endpackage

[rtl/core/interval_reservation_table_top.sv]
// ----------------------------------------------------------------------------
// interval_reservation_table_top: Interval reservation table
// Books non-overlapping half-open intervals [start, end) in a slot memory.
//
//   Channel   Ports                                   Handshake
//   request   in_range_start, in_range_end            start high, busy low
//   result    out_status, out_entries_used            out_valid, one cycle
//
// An empty or reversed interval is answered in the cycle after it is taken and
// leaves busy low. A valid request makes one read of the slot memory per
// booked slot, then a final compare and decide step.
// Reset clears the fill count; slots above the count are never read, so the
// memory needs no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module interval_reservation_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [irt_pkg::IN_W-1:0]     in_range_start,
  input  logic [irt_pkg::IN_W-1:0]     in_range_end,
  output logic                         out_valid,
  output logic [irt_pkg::STATUS_W-1:0] out_status,
  output logic [irt_pkg::USED_W-1:0]   out_entries_used
);

  irt_pkg::mem_req_t             mem_req;
  logic [irt_pkg::SLOT_W-1:0]    rdata;
  logic                          rvalid;
  logic                          cmp_clear;
  logic                          clash;
  logic [irt_pkg::TIME_BITS-1:0] req_start;
  logic [irt_pkg::TIME_BITS-1:0] req_end;

  // Request sequencing, booking and result register.
  irt_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entries_used (out_entries_used),
    .mem_req          (mem_req),
    .rvalid           (rvalid),
    .cmp_clear        (cmp_clear),
    .clash            (clash),
    .req_start        (req_start),
    .req_end          (req_end)
  );

  // Slot memory holding {start, end} for each booked interval.
  irt_ram #(
    .WIDTH (irt_pkg::SLOT_W),
    .DEPTH (irt_pkg::TABLE_ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // Overlap test of each slot against the pending request.
  irt_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cmp_clear),
    .rvalid    (rvalid),
    .rdata     (rdata),
    .req_start (req_start),
    .req_end   (req_end),
    .clash     (clash)
  );

endmodule

[rtl/core/irt_ram.sv]
// ----------------------------------------------------------------------------
// irt_ram: Generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module irt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/irt_cmp.sv]
// ----------------------------------------------------------------------------
// irt_cmp: Overlap comparator
// Tests each slot read back from memory against the pending request and
// accumulates a conflict flag over the scan.
// ----------------------------------------------------------------------------
module irt_cmp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         rvalid,
  input  logic [irt_pkg::SLOT_W-1:0]   rdata,
  input  logic [irt_pkg::TIME_BITS-1:0] req_start,
  input  logic [irt_pkg::TIME_BITS-1:0] req_end,
  output logic                         clash
);

  logic [irt_pkg::TIME_BITS-1:0] slot_start;
  logic [irt_pkg::TIME_BITS-1:0] slot_end;
  logic                          hit;
  logic                          clash_r;
  logic                          clash_nxt;

  // Slot layout is {start, end}.
  assign slot_start = rdata[irt_pkg::SLOT_W-1:irt_pkg::TIME_BITS];
  assign slot_end   = rdata[irt_pkg::TIME_BITS-1:0];

  // Half-open intervals overlap when each starts before the other ends.
  assign hit = rvalid && (slot_start < req_end) && (req_start < slot_end);

  assign clash_nxt = clear ? 1'b0 : (clash_r | hit);

  // Sticky conflict flag for the item under test.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clash_r <= 1'b0;
    end else begin
      clash_r <= clash_nxt;
    end
  end

  assign clash = clash_r | hit;

endmodule

[rtl/core/irt_ctrl.sv]
// ----------------------------------------------------------------------------
// irt_ctrl: Reservation controller
// Accepts requests, scans the occupied slots through the memory, decides
// the status, books the interval in the next free slot and posts the result.
// ----------------------------------------------------------------------------
module irt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [irt_pkg::IN_W-1:0]      in_range_start,
  input  logic [irt_pkg::IN_W-1:0]      in_range_end,
  output logic                          out_valid,
  output logic [irt_pkg::STATUS_W-1:0]  out_status,
  output logic [irt_pkg::USED_W-1:0]    out_entries_used,
  output irt_pkg::mem_req_t             mem_req,
  output logic                          rvalid,
  output logic                          cmp_clear,
  input  logic                          clash,
  output logic [irt_pkg::TIME_BITS-1:0] req_start,
  output logic [irt_pkg::TIME_BITS-1:0] req_end
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  localparam logic [irt_pkg::CNT_W-1:0] FULL_CNT =
    irt_pkg::CNT_W'(irt_pkg::TABLE_ENTRIES);

  logic [1:0]                       state_r, state_nxt;
  logic [irt_pkg::CNT_W-1:0]        fill_r, fill_nxt;
  logic [irt_pkg::CNT_W-1:0]        addr_r, addr_nxt;
  logic                             rvalid_r, rvalid_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [irt_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [irt_pkg::TIME_BITS-1:0]    req_start_r, req_end_r;
  logic [irt_pkg::TIME_BITS-1:0]    in_s, in_e;
  logic                             accept;

  // Requests are taken modulo the time width.
  assign in_s   = irt_pkg::TIME_BITS'(in_range_start);
  assign in_e   = irt_pkg::TIME_BITS'(in_range_end);
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Sequencer: scan reads slots 0 .. fill-1, one per cycle.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    addr_nxt       = addr_r;
    rvalid_nxt     = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    cmp_clear      = 1'b0;
    mem_req.we     = 1'b0;
    mem_req.re     = 1'b0;
    mem_req.addr   = addr_r[irt_pkg::ADDR_W-1:0];
    mem_req.wdata  = {req_start_r, req_end_r};
    unique case (state_r)
      S_IDLE: begin
        cmp_clear = 1'b1;
        addr_nxt  = '0;
        if (accept) begin
          if (in_s >= in_e) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = irt_pkg::ST_INVALID;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (addr_r != fill_r) begin
          mem_req.re = 1'b1;
          rvalid_nxt = 1'b1;
          addr_nxt   = addr_r + 1'b1;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (clash) begin
          out_status_nxt = irt_pkg::ST_CONFLICT;
        end else if (fill_r == FULL_CNT) begin
          out_status_nxt = irt_pkg::ST_FULL;
        end else begin
          mem_req.we     = 1'b1;
          mem_req.addr   = fill_r[irt_pkg::ADDR_W-1:0];
          fill_nxt       = fill_r + 1'b1;
          out_status_nxt = irt_pkg::ST_BOOKED;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      addr_r      <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      addr_r      <= addr_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: request capture and result status.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_start_r <= in_s;
      req_end_r   <= in_e;
    end
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entries_used = irt_pkg::USED_W'(fill_r);
  assign rvalid           = rvalid_r;
  assign req_start        = req_start_r;
  assign req_end          = req_end_r;

`ifndef NO_ASSERTIONS
  // The count of booked slots never exceeds the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond table depth");

  // A slot is written only while a free slot remains.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (fill_r < FULL_CNT) && (state_r == S_FINISH))
    else $error("slot write without a free slot");

  // A booked result comes with exactly one more stored interval.
  a_book_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == irt_pkg::ST_BOOKED) |->
      fill_r == $past(fill_r) + 1'b1)
    else $error("booking did not advance the fill count");

  // Read data only arrives during the scan or its final compare.
  a_rvalid_state: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> (state_r == S_SCAN) || (state_r == S_FINISH))
    else $error("read data outside of a scan");
`endif

endmodule
